/* sv/rwla_pkg.sv */
// Shared types, codes and sizes of the reader-writer lock arbiter.
package rwla_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 16;
  localparam int unsigned ID_W            = 4;
  localparam int unsigned ID_SPACE        = 16;
  localparam int unsigned CMD_FIFO_DEPTH  = 2;
  localparam int unsigned RES_FIFO_DEPTH  = 4;

  typedef enum logic {
    OP_LOCK    = 1'b0,
    OP_RELEASE = 1'b1
  } opcode_e;

  typedef enum logic {
    KIND_ACK   = 1'b0,
    KIND_GRANT = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_DUP  = 2'd2,
    ST_NOTQ = 2'd3
  } status_e;

  typedef struct packed {
    opcode_e          opcode;
    logic             is_reader;
    logic [ID_W-1:0]  waiter_id;
  } cmd_t;

  typedef struct packed {
    kind_e            item_kind;
    logic [ID_W-1:0]  waiter_id;
    status_e          status;
    logic             last;
  } res_t;

  typedef enum logic [2:0] {
    ENG_IDLE  = 3'b001,
    ENG_EXEC  = 3'b010,
    ENG_GRANT = 3'b100
  } eng_state_e;

endpackage

/* sv/reader_writer_lock_arbiter_core.sv */
// Top level of the reader-writer lock arbiter: command queue, engine, result queue.
//
// Each word pushed in is a lock request or a release for a 4-bit waiter id.
// Every word yields one acknowledgement carrying a status (ok, queue full,
// id already queued, id not queued), followed by zero or more grant words in
// arrival order; the last word of each group has last_o set. A request is
// granted at once when no writer holds the lock and it is a reader or no
// readers hold it. When a release frees the lock, the head of the queue is
// granted; a reader head brings every waiting reader with it. Flow: an
// incoming word waits in a two-entry command queue, then the engine fetches
// it (ENG_IDLE), issues the acknowledgement (ENG_EXEC) and the grants
// (ENG_GRANT); the grant sequencer retires one grant per cycle while the
// result queue has room, and the next word is fetched only after the last
// grant. Results sit in a four-entry result queue, so the engine keeps
// working while the consumer stalls, and holds only when that queue is full.
module reader_writer_lock_arbiter_core import rwla_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push,
  output logic            full,
  input  logic            opcode_i,
  input  logic            is_reader_i,
  input  logic [ID_W-1:0] waiter_id_i,
  output logic            empty,
  input  logic            pop,
  output logic            item_kind_o,
  output logic [ID_W-1:0] waiter_id_res_o,
  output logic [1:0]      status_o,
  output logic            last_o
);

  cmd_t in_cmd, eng_cmd;
  res_t eng_res, out_res;
  logic cmd_empty, cmd_pop, res_full, res_push;

  // Pack the incoming fields into a command word.
  assign in_cmd = '{opcode: opcode_e'(opcode_i), is_reader: is_reader_i,
                    waiter_id: waiter_id_i};

  // Front: hold incoming words until the engine takes them.
  rwla_fifo #(
    .Width($bits(cmd_t)),
    .Depth(CMD_FIFO_DEPTH)
  ) u_cmd_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (in_cmd),
    .full_o (full),
    .pop_i  (cmd_pop),
    .data_o (eng_cmd),
    .empty_o(cmd_empty)
  );

  // Back: classify, update the queue and lock state, sequence the grants.
  rwla_engine #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_engine (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_empty_i(cmd_empty),
    .cmd_i      (eng_cmd),
    .cmd_pop_o  (cmd_pop),
    .res_full_i (res_full),
    .res_o      (eng_res),
    .res_push_o (res_push)
  );

  // Result queue: decouple the engine from a stalling consumer.
  rwla_fifo #(
    .Width($bits(res_t)),
    .Depth(RES_FIFO_DEPTH)
  ) u_res_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_push),
    .data_i (eng_res),
    .full_o (res_full),
    .pop_i  (pop),
    .data_o (out_res),
    .empty_o(empty)
  );

  // Unpack the oldest result word onto the ports.
  assign item_kind_o     = out_res.item_kind;
  assign waiter_id_res_o = out_res.waiter_id;
  assign status_o        = out_res.status;
  assign last_o          = out_res.last;

endmodule

/* sv/rwla_fifo.sv */
// Small register FIFO used for the command queue and the result queue.
module rwla_fifo import rwla_pkg::*; #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned AddrW = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [AddrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + AddrW'(1) : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + AddrW'(1) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

/* sv/rwla_engine.sv */
// Back end: waiter queue, lock state and the grant sequencer.
module rwla_engine import rwla_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cmd_empty_i,
  input  cmd_t cmd_i,
  output logic cmd_pop_o,
  input  logic res_full_i,
  output res_t res_o,
  output logic res_push_o
);

  // Ids are unique in the queue, so no more than ID_SPACE entries are ever live.
  localparam int unsigned Slots = (QUEUE_DEPTH < ID_SPACE) ? QUEUE_DEPTH : ID_SPACE;
  localparam int unsigned CntW  = $clog2(Slots + 1);

  eng_state_e       state_q, state_d;
  cmd_t             cmd_q, cmd_d;
  logic [CntW-1:0]  count_q, count_d;
  logic [CntW-1:0]  readers_q, readers_d;
  logic             writer_q, writer_d;
  logic [ID_W-1:0]  id_q [Slots];
  logic [ID_W-1:0]  id_d [Slots];
  logic [Slots-1:0] rd_q, rd_d, gr_q, gr_d, mask_q, mask_d;

  logic [Slots-1:0] valid, match, tail_sel, shift_en, valid_n, rd_n, gr_n;
  logic [ID_W-1:0]  id_n [Slots];
  logic [Slots-1:0] next_mask, rel_mask, pick, mask_rest;
  logic             hit, was_gr, was_rd, q_full, lock_grant, release_grant;
  logic             seen, found, g_rd;
  logic [CntW-1:0]  cnt_rel, rd_after;
  logic [ID_W-1:0]  g_id;

  // Lookup, tail position and removal with compaction.
  always_comb begin
    seen    = 1'b0;
    cnt_rel = count_q - CntW'(1);
    for (int i = 0; i < Slots; i++) begin
      valid[i]    = (CntW'(i) < count_q);
      valid_n[i]  = (CntW'(i) < cnt_rel);
      match[i]    = valid[i] && (id_q[i] == cmd_q.waiter_id);
      tail_sel[i] = (CntW'(i) == count_q);
      seen        = seen | match[i];
      shift_en[i] = seen;
    end
    for (int i = 0; i < Slots - 1; i++) begin
      id_n[i] = shift_en[i] ? id_q[i+1] : id_q[i];
      rd_n[i] = shift_en[i] ? rd_q[i+1] : rd_q[i];
      gr_n[i] = shift_en[i] ? gr_q[i+1] : gr_q[i];
    end
    id_n[Slots-1] = id_q[Slots-1];
    rd_n[Slots-1] = rd_q[Slots-1];
    gr_n[Slots-1] = gr_q[Slots-1];
  end

  assign hit      = |match;
  assign was_gr   = |(match & gr_q);
  assign was_rd   = |(match & rd_q);
  assign q_full   = (count_q == CntW'(Slots));
  assign rd_after = (readers_q == '0) ? '0 : readers_q - CntW'(1);

  assign lock_grant    = !writer_q && (cmd_q.is_reader || (readers_q == '0));
  assign release_grant = was_gr && (!was_rd || (rd_after == '0));

  // Grant set after a release: all waiting readers behind a reader head,
  // or the head writer alone.
  assign next_mask = rd_n[0] ? (rd_n & ~gr_n & valid_n)
                             : {{(Slots-1){1'b0}}, valid_n[0] & ~gr_n[0]};
  assign rel_mask  = release_grant ? next_mask : '0;

  // Oldest pending grant.
  always_comb begin
    found = 1'b0;
    g_id  = '0;
    for (int i = 0; i < Slots; i++) begin
      pick[i] = mask_q[i] && !found;
      found   = found | mask_q[i];
      g_id    = g_id | (pick[i] ? id_q[i] : '0);
    end
  end

  assign g_rd      = |(pick & rd_q);
  assign mask_rest = mask_q & ~pick;

  always_comb begin
    state_d    = state_q;
    cmd_d      = cmd_q;
    count_d    = count_q;
    readers_d  = readers_q;
    writer_d   = writer_q;
    id_d       = id_q;
    rd_d       = rd_q;
    gr_d       = gr_q;
    mask_d     = mask_q;
    cmd_pop_o  = 1'b0;
    res_push_o = 1'b0;
    res_o      = '{item_kind: KIND_ACK, waiter_id: cmd_q.waiter_id, status: ST_OK,
                   last: 1'b1};
    unique case (state_q)
      ENG_IDLE: begin
        if (!cmd_empty_i) begin
          cmd_pop_o = 1'b1;
          cmd_d     = cmd_i;
          state_d   = ENG_EXEC;
        end
      end
      ENG_EXEC: begin
        if (!res_full_i) begin
          res_push_o = 1'b1;
          state_d    = ENG_IDLE;
          if (cmd_q.opcode == OP_LOCK) begin
            if (hit) begin
              res_o.status = ST_DUP;
            end else if (q_full) begin
              res_o.status = ST_FULL;
            end else begin
              for (int i = 0; i < Slots; i++) begin
                if (tail_sel[i]) begin
                  id_d[i] = cmd_q.waiter_id;
                  rd_d[i] = cmd_q.is_reader;
                  gr_d[i] = 1'b0;
                end
              end
              count_d = count_q + CntW'(1);
              if (lock_grant) begin
                res_o.last = 1'b0;
                mask_d     = tail_sel;
                state_d    = ENG_GRANT;
              end
            end
          end else begin
            if (!hit) begin
              res_o.status = ST_NOTQ;
            end else begin
              id_d    = id_n;
              rd_d    = rd_n;
              gr_d    = gr_n;
              count_d = cnt_rel;
              if (was_gr && was_rd) begin
                readers_d = rd_after;
              end
              if (was_gr && !was_rd) begin
                writer_d = 1'b0;
              end
              if (rel_mask != '0) begin
                res_o.last = 1'b0;
                mask_d     = rel_mask;
                state_d    = ENG_GRANT;
              end
            end
          end
        end
      end
      ENG_GRANT: begin
        if (!res_full_i) begin
          res_push_o      = 1'b1;
          res_o.item_kind = KIND_GRANT;
          res_o.waiter_id = g_id;
          res_o.last      = (mask_rest == '0);
          gr_d            = gr_q | pick;
          mask_d          = mask_rest;
          if (g_rd) begin
            readers_d = readers_q + CntW'(1);
          end else begin
            writer_d = 1'b1;
          end
          if (mask_rest == '0) begin
            state_d = ENG_IDLE;
          end
        end
      end
      default: begin
        state_d = ENG_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ENG_IDLE;
      count_q   <= '0;
      readers_q <= '0;
      writer_q  <= 1'b0;
      mask_q    <= '0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      readers_q <= readers_d;
      writer_q  <= writer_d;
      mask_q    <= mask_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    id_q  <= id_d;
    rd_q  <= rd_d;
    gr_q  <= gr_d;
  end

endmodule
